>>> rtl/core/sm4_pkg.sv
package sm4_pkg;

    // Control of one word cell: hold, shift towards index 0, shift back, or load
    typedef struct packed {
        logic en;
        logic load;
        logic back;
    } cell_ctl_t;

    // Control of the round-key ring
    typedef struct packed {
        logic en;
        logic back;
        logic fill;
    } ring_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_CRYPT
    } state_t;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] KEY_HIGH_IDX = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] KEY_LOW_IDX  = 8'd1;

    localparam logic [31:0] FK [4] = '{
        32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
    };

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
        8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
        8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
        8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
        8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
        8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
        8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
        8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
        8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
        8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
        8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
        8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
        8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
        8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
        8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
        8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
        8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    function automatic logic [31:0] sbox_word(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [31:0] lin_data(input logic [31:0] b);
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

    function automatic logic [31:0] lin_key(input logic [31:0] b);
        return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
    endfunction

    // Byte j of CK[i] is (4i + j) * 7 modulo 256
    function automatic logic [31:0] ck_word(input logic [7:0] i);
        logic [31:0] w;
        logic [7:0]  b;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            b = 8'(({i[5:0], 2'b00} + 8'(j)) * 8'd7);
            w = {w[23:0], b};
        end
        return w;
    endfunction

endpackage

>>> rtl/core/sm4_word_cell.sv
module sm4_word_cell (
    input  logic                 clk,
    input  sm4_pkg::cell_ctl_t   ctl,
    input  logic [31:0]          load_word,
    input  logic [31:0]          up_word,
    input  logic [31:0]          down_word,
    output logic [31:0]          q
);

    logic [31:0] q_reg;
    logic [31:0] q_next;

    always_comb
    begin
        priority if (ctl.load)
            q_next = load_word;
        else if (ctl.back)
            q_next = down_word;
        else
            q_next = up_word;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

>>> rtl/core/sm4_round.sv
module sm4_round (
    input  logic        key_mode,
    input  logic [31:0] x0,
    input  logic [31:0] x1,
    input  logic [31:0] x2,
    input  logic [31:0] x3,
    input  logic [31:0] rk,
    input  logic [31:0] ck,
    output logic [31:0] t
);

    logic [31:0] mix;
    logic [31:0] sub;

    // Key schedule mixes in CK and uses L'; the data path uses the round key and L
    always_comb
    begin
        mix = x1 ^ x2 ^ x3 ^ (key_mode ? ck : rk);
        sub = sm4_pkg::sbox_word(mix);
        t   = x0 ^ (key_mode ? sm4_pkg::lin_key(sub) : sm4_pkg::lin_data(sub));
    end

endmodule

>>> rtl/core/sm4_key_ring.sv
module sm4_key_ring #(
    parameter int DEPTH = 32
) (
    input  logic                 clk,
    input  sm4_pkg::ring_ctl_t   ctl,
    input  logic [31:0]          fill_word,
    output logic [31:0]          head,
    output logic [31:0]          tail
);

    logic [31:0]        rk [DEPTH];
    sm4_pkg::cell_ctl_t cell_ctl [DEPTH];

    // Forward: each cell takes its upper neighbour, the top one wraps or takes
    // the new key. Back: each cell takes its lower neighbour.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        always_comb
        begin
            cell_ctl[i].en   = ctl.en;
            cell_ctl[i].back = ctl.back;
            cell_ctl[i].load = ctl.fill && (i == DEPTH - 1);
        end

        sm4_word_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl[i]),
            .load_word (fill_word),
            .up_word   (rk[(i + 1) % DEPTH]),
            .down_word (rk[(i + DEPTH - 1) % DEPTH]),
            .q         (rk[i])
        );
    end

    assign head = rk[0];
    assign tail = rk[DEPTH-1];

endmodule

>>> rtl/core/sm4_block_cipher.sv
// SM4 block cipher, 128-bit block under a 128-bit key. A beat on the slave
// side carries one block (tdata) and the operation in tuser (0 encrypt,
// 1 decrypt); one result beat leaves on the master side for every block.
// The key is written through the configuration channel as two 64-bit words
// (index 0 key bytes 0 to 7, index 1 key bytes 8 to 15, big-endian); write it
// only while the core is idle. One shared round unit does one round per cycle
// unless the core holds on a last round: the four state words sit in a chain
// of word cells that advance by one word each round, and the 32 round keys sit
// in a ring of word cells that rotates forward for encryption and backward for
// decryption, so a full pass returns it to its starting place. A block loads
// on its accepting edge, then 32 rounds run; its result is offered as the core
// returns to idle, and the next block can be taken in that same cycle, but not
// before the previous block's rounds are through. The first block after reset
// or after any key write first runs the key schedule through the same round
// unit and cell chain. The result register lets the next block be taken while
// the previous result still waits; if that result has still not been taken
// when the last round comes up, the core holds there until it is.
module sm4_block_cipher #(
    parameter int ROUND_COUNT = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sm4_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [63:0]                       cfg_data,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [127:0]                      s_tdata,   // block_high [63:0], block_low [127:64]
    input  logic                              s_tuser,   // func [0]
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [127:0]                      m_tdata    // result_high [63:0], result_low [127:64]
);

    localparam int CNT_W = $clog2(ROUND_COUNT);
    localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUND_COUNT - 1);

    sm4_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]    rnd_cnt_reg, rnd_cnt_next;
    logic                keys_ready_reg;
    logic [63:0]         key_high_reg, key_low_reg;
    logic [127:0]        blk_reg;
    logic                dec_reg;
    logic                m_tvalid_reg;
    logic [127:0]        m_tdata_reg;

    logic                accept;
    logic                last_rnd;
    logic                out_free;
    logic                chain_en;
    logic                load_all;
    logic                keys_set;
    logic                out_load;
    logic [31:0]         load_words [4];
    logic [31:0]         x [4];
    logic [31:0]         t;
    logic [31:0]         rk;
    logic [31:0]         ring_head, ring_tail;
    sm4_pkg::ring_ctl_t  ring_ctl;
    sm4_pkg::cell_ctl_t  data_ctl [4];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == sm4_pkg::ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign last_rnd  = (rnd_cnt_reg == LAST_RND);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign rk        = dec_reg ? ring_tail : ring_head;

    // Words to load into the state chain: the key whitened with FK ahead of
    // the schedule, else the block straight off the bus or from the holding
    // register once the schedule is done.
    always_comb
    begin
        if (state_reg == sm4_pkg::ST_IDLE && !keys_ready_reg)
        begin
            load_words[0] = key_high_reg[63:32] ^ sm4_pkg::FK[0];
            load_words[1] = key_high_reg[31:0]  ^ sm4_pkg::FK[1];
            load_words[2] = key_low_reg[63:32]  ^ sm4_pkg::FK[2];
            load_words[3] = key_low_reg[31:0]   ^ sm4_pkg::FK[3];
        end
        else if (state_reg == sm4_pkg::ST_IDLE)
        begin
            load_words[0] = s_tdata[63:32];
            load_words[1] = s_tdata[31:0];
            load_words[2] = s_tdata[127:96];
            load_words[3] = s_tdata[95:64];
        end
        else
        begin
            load_words[0] = blk_reg[63:32];
            load_words[1] = blk_reg[31:0];
            load_words[2] = blk_reg[127:96];
            load_words[3] = blk_reg[95:64];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        rnd_cnt_next = rnd_cnt_reg;
        chain_en     = 1'b0;
        load_all     = 1'b0;
        keys_set     = 1'b0;
        out_load     = 1'b0;
        ring_ctl     = '0;
        unique case (state_reg)
            sm4_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    chain_en     = 1'b1;
                    load_all     = 1'b1;
                    rnd_cnt_next = '0;
                    state_next   = keys_ready_reg ? sm4_pkg::ST_CRYPT : sm4_pkg::ST_EXPAND;
                end
            end
            sm4_pkg::ST_EXPAND:
            begin
                // Shift each new round key into the top of the ring
                chain_en      = 1'b1;
                ring_ctl.en   = 1'b1;
                ring_ctl.fill = 1'b1;
                rnd_cnt_next  = rnd_cnt_reg + CNT_W'(1);
                if (last_rnd)
                begin
                    load_all   = 1'b1;
                    keys_set   = 1'b1;
                    state_next = sm4_pkg::ST_CRYPT;
                end
            end
            sm4_pkg::ST_CRYPT:
            begin
                // Hold on the last round until the result register is free
                if (!last_rnd || out_free)
                begin
                    chain_en      = 1'b1;
                    ring_ctl.en   = 1'b1;
                    ring_ctl.back = dec_reg;
                    rnd_cnt_next  = rnd_cnt_reg + CNT_W'(1);
                    if (last_rnd)
                    begin
                        out_load   = 1'b1;
                        state_next = sm4_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sm4_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sm4_pkg::ST_IDLE;
            rnd_cnt_reg    <= '0;
            keys_ready_reg <= 1'b0;
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rnd_cnt_reg <= rnd_cnt_next;
            if (cfg_valid && cfg_ready && cfg_index == sm4_pkg::KEY_HIGH_IDX)
            begin
                key_high_reg   <= cfg_data;
                keys_ready_reg <= 1'b0;
            end
            else if (cfg_valid && cfg_ready && cfg_index == sm4_pkg::KEY_LOW_IDX)
            begin
                key_low_reg    <= cfg_data;
                keys_ready_reg <= 1'b0;
            end
            else if (keys_set)
            begin
                keys_ready_reg <= 1'b1;
            end
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Payload registers: held block, operation and result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg <= s_tdata;
            dec_reg <= s_tuser;
        end
        // Final words reversed: the new word and the top of the chain form
        // the high half, the next two the low half
        if (out_load)
            m_tdata_reg <= {x[2], x[1], t, x[3]};
    end

    // State chain: four word cells, each taking its upper neighbour; the top
    // cell takes the round output
    for (genvar i = 0; i < 4; i++)
    begin : g_chain
        always_comb
        begin
            data_ctl[i].en   = chain_en;
            data_ctl[i].load = load_all || (i == 3);
            data_ctl[i].back = 1'b0;
        end

        sm4_word_cell u_cell (
            .clk       (clk),
            .ctl       (data_ctl[i]),
            .load_word (load_all ? load_words[i] : t),
            .up_word   (x[(i + 1) % 4]),
            .down_word (x[(i + 3) % 4]),
            .q         (x[i])
        );
    end

    sm4_round u_round (
        .key_mode (state_reg == sm4_pkg::ST_EXPAND),
        .x0       (x[0]),
        .x1       (x[1]),
        .x2       (x[2]),
        .x3       (x[3]),
        .rk       (rk),
        .ck       (sm4_pkg::ck_word(8'(rnd_cnt_reg))),
        .t        (t)
    );

    sm4_key_ring #(
        .DEPTH (ROUND_COUNT)
    ) u_key_ring (
        .clk       (clk),
        .ctl       (ring_ctl),
        .fill_word (t),
        .head      (ring_head),
        .tail      (ring_tail)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> rtl/core/sm4_chk.sv
module sm4_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready
);

    // Drop ready once a block is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after an accepted beat");

    // All 32 rounds run before the next block can enter
    a_rounds_span: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##31 !s_tready)
        else $error("core ready before the rounds are through");

    // A result only appears at the end of a block's rounds
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while no block was in work");

    // Hold a stalled result beat
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind sm4_block_cipher sm4_chk u_sm4_chk (.*);
